FILE: hw/rtl/g2e_pkg.sv
// Shared types, constants and tables for the geodetic to ECEF converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package g2e_pkg;

	localparam int ANGLE_FRAC_BITS = 29;
	localparam int CORDIC_STAGES   = 32;
	localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;
	localparam int ANG_W           = 33;

	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
	localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
	localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;

	localparam logic [35:0] N_MAX = 36'h8_0000_0000;
	localparam int QUOT_BITS = 36;

	localparam logic signed [37:0] OUT_MAX = 38'sd17179869183;
	localparam logic signed [37:0] OUT_MIN = -38'sd17179869184;

	localparam logic [22:0] AXIS_RESET = 23'd6378137;
	localparam logic [31:0] ECC_RESET  = 32'd28752143;

	localparam logic [0:0] REG_AXIS = 1'b0;
	localparam logic [0:0] REG_ECC  = 1'b1;

	// pipeline depths
	localparam int CORDIC_LAT = CORDIC_STAGES + 3;
	localparam int PREP_LAT   = 4;
	localparam int ISQRT_LAT  = 32;
	localparam int DIV_LAT    = QUOT_BITS + 3;
	localparam int NSC_LAT    = 3;
	localparam int MUL_LAT    = 4;
	localparam int TOTAL_LAT  = CORDIC_LAT + PREP_LAT + ISQRT_LAT + DIV_LAT + NSC_LAT
		+ 2 * MUL_LAT + 1;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [30:0] atan_entry(input int i);
		logic [30:0] r;
		unique case (i)
			0: r = 31'h3243F6A8;
			1: r = 31'h1DAC6705;
			2: r = 31'h0FADBAFC;
			3: r = 31'h07F56EA6;
			4: r = 31'h03FEAB76;
			5: r = 31'h01FFD55B;
			6: r = 31'h00FFFAAA;
			7: r = 31'h007FFF55;
			8: r = 31'h003FFFEA;
			9: r = 31'h001FFFFD;
			default: r = (i <= 30) ? 31'((64'd1 << (30 - i)) - 64'd1) : 31'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/geodetic_to_ecef_top.sv
// Top level of the WGS84-style geodetic to ECEF converter.
// Depends on g2e_pkg, g2e_cordic, g2e_isqrt, g2e_div, g2e_smul.
//
// Usage:
//  - Input beat: latitude, longitude (Q29 rad) and height (Q10 m) are taken
//    at a rising edge with start high and busy low. busy is always low: the
//    pipeline takes one beat per clock, every clock.
//  - Output beat: done pulses for one cycle with ecef_x/y/z (Q10 m). The
//    receiver cannot stall and the pipeline never needs to: nothing is held.
//  - Depth: TOTAL_LAT, the sum of all stage depths, mostly the CORDIC chain,
//    the 32-step square root and the 36-step divider.
//  - Throughput: one beat per cycle, beats stay in order.
//  - Config: wr_en/wr_index/wr_data set semi_major_axis (index 0), ecc_squared
//    (index 1); the user writes only while no beat is in flight (unchecked).
//  - Reset: arst_n clears all valid bits and loads the default ellipsoid;
//    beats in flight are dropped.
`timescale 1ns / 1ps

module geodetic_to_ecef_top
	import g2e_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic signed [30:0] height,
	output logic signed [34:0] ecef_x,
	output logic signed [34:0] ecef_y,
	output logic signed [34:0] ecef_z,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [31:0]        wr_data
);

	// delay depths for side data, counted in registers
	localparam int H_DLY  = CORDIC_LAT + PREP_LAT + ISQRT_LAT + DIV_LAT;
	localparam int SC_DLY = PREP_LAT + ISQRT_LAT + DIV_LAT + NSC_LAT;
	localparam int LO_DLY = SC_DLY + MUL_LAT;

	logic [22:0] axis_q;
	logic [31:0] ecc_q;

	logic                    in_fire;
	logic signed [ANG_W-1:0] lat_q30;
	logic signed [ANG_W-1:0] lon_q30;

	logic               cs_valid;
	logic signed [31:0] sin_lat;
	logic signed [31:0] cos_lat;
	logic signed [31:0] sin_lon;
	logic signed [31:0] cos_lon;

	logic signed [63:0] sq_full;
	logic [60:0] sq_s1;
	logic [32:0] s2_s2;
	logic [64:0] prod_s3;
	logic [65:0] e2s2_sum;
	logic [32:0] d_s4;
	logic        v_s1, v_s2, v_s3, v_s4;

	logic        root_valid;
	logic [31:0] root;
	logic        n_valid;
	logic [35:0] n_val;

	logic signed [30:0] h_dly_s [H_DLY];
	logic signed [31:0] cl_dly_s [SC_DLY];
	logic signed [31:0] sl_dly_s [SC_DLY];
	logic signed [31:0] co_dly_s [LO_DLY];
	logic signed [31:0] so_dly_s [LO_DLY];
	logic signed [37:0] z_dly_s [MUL_LAT];

	logic [32:0]        nzc;
	logic signed [37:0] nh_e1, nh_e2, nh_e3;
	logic signed [30:0] h_e1, h_e2;
	logic [51:0]        plo_e1;
	logic [52:0]        phi_e1;
	logic [69:0]        nz_sum;
	logic [35:0]        nzu_e2;
	logic signed [37:0] nz_e3;
	logic               v_e1, v_e2, v_e3;

	logic               t1_valid;
	logic signed [37:0] t1;
	logic signed [37:0] zr;
	logic               x_valid;
	logic signed [37:0] xr;
	logic signed [37:0] yr;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_RESET;
			ecc_q  <= ECC_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_AXIS: axis_q <= wr_data[22:0];
				REG_ECC:  ecc_q  <= wr_data;
			endcase
		end
	end

	assign busy    = 1'b0;
	assign in_fire = start && !busy;
	assign lat_q30 = ANG_W'(latitude) <<< ANG_SHIFT;
	assign lon_q30 = ANG_W'(longitude) <<< ANG_SHIFT;

	g2e_cordic u_cordic_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_fire),
		.angle     (lat_q30),
		.out_valid (cs_valid),
		.sin_val   (sin_lat),
		.cos_val   (cos_lat)
	);

	g2e_cordic u_cordic_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_fire),
		.angle     (lon_q30),
		.out_valid (),
		.sin_val   (sin_lon),
		.cos_val   (cos_lon)
	);

	// 1 - e2 sin^2 lat, in Q32
	assign sq_full  = sin_lat * sin_lat;
	assign e2s2_sum = 66'(prod_s3) + (66'd1 << 31);

	always_ff @(posedge clk) begin
		sq_s1   <= sq_full[60:0];
		s2_s2   <= 33'((62'(sq_s1) + (62'd1 << 27)) >> 28);
		prod_s3 <= ecc_q * s2_s2;
		d_s4    <= 33'h1_0000_0000 - e2s2_sum[64:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cs_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	g2e_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.radicand  ({d_s4, 30'd0}),
		.out_valid (root_valid),
		.root      (root)
	);

	g2e_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_valid),
		.axis      (axis_q),
		.root      (root),
		.out_valid (n_valid),
		.radius    (n_val)
	);

	// side data delay lines
	always_ff @(posedge clk) begin
		h_dly_s[0]  <= height;
		cl_dly_s[0] <= cos_lat;
		sl_dly_s[0] <= sin_lat;
		co_dly_s[0] <= cos_lon;
		so_dly_s[0] <= sin_lon;
		z_dly_s[0]  <= zr;
		for (int i = 1; i < H_DLY; i++) begin
			h_dly_s[i] <= h_dly_s[i-1];
		end
		for (int i = 1; i < SC_DLY; i++) begin
			cl_dly_s[i] <= cl_dly_s[i-1];
			sl_dly_s[i] <= sl_dly_s[i-1];
		end
		for (int i = 1; i < LO_DLY; i++) begin
			co_dly_s[i] <= co_dly_s[i-1];
			so_dly_s[i] <= so_dly_s[i-1];
		end
		for (int i = 1; i < MUL_LAT; i++) begin
			z_dly_s[i] <= z_dly_s[i-1];
		end
	end

	// N + h and N(1 - e2) + h
	assign nzc    = 33'h1_0000_0000 - {1'b0, ecc_q};
	assign nz_sum = (70'(phi_e1) << 16) + 70'(plo_e1) + (70'd1 << 31);

	always_ff @(posedge clk) begin
		nh_e1  <= $signed({2'b00, n_val}) + 38'(h_dly_s[H_DLY-1]);
		h_e1   <= h_dly_s[H_DLY-1];
		plo_e1 <= n_val * nzc[15:0];
		phi_e1 <= n_val * nzc[32:16];
		nh_e2  <= nh_e1;
		h_e2   <= h_e1;
		nzu_e2 <= nz_sum[67:32];
		nh_e3  <= nh_e2;
		nz_e3  <= $signed({2'b00, nzu_e2}) + 38'(h_e2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
		end else begin
			v_e1 <= n_valid;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
		end
	end

	g2e_smul u_mul_ncl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_e3),
		.len       (nh_e3),
		.factor    (cl_dly_s[SC_DLY-1]),
		.out_valid (t1_valid),
		.product   (t1)
	);

	g2e_smul u_mul_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_e3),
		.len       (nz_e3),
		.factor    (sl_dly_s[SC_DLY-1]),
		.out_valid (),
		.product   (zr)
	);

	g2e_smul u_mul_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t1_valid),
		.len       (t1),
		.factor    (co_dly_s[LO_DLY-1]),
		.out_valid (x_valid),
		.product   (xr)
	);

	g2e_smul u_mul_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t1_valid),
		.len       (t1),
		.factor    (so_dly_s[LO_DLY-1]),
		.out_valid (),
		.product   (yr)
	);

	function automatic logic signed [34:0] sat35(input logic signed [37:0] v);
		logic signed [34:0] r;
		if (v > OUT_MAX) begin
			r = 35'(OUT_MAX);
		end else if (v < OUT_MIN) begin
			r = 35'(OUT_MIN);
		end else begin
			r = 35'(v);
		end
		return r;
	endfunction

	// output register
	always_ff @(posedge clk) begin
		ecef_x <= sat35(xr);
		ecef_y <= sat35(yr);
		ecef_z <= sat35(z_dly_s[MUL_LAT-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= x_valid;
		end
	end

endmodule

FILE: hw/rtl/g2e_cordic.sv
// Angle wrap/fold plus unrolled rotation-mode CORDIC, one stage per register.
// Depends on g2e_pkg.
`timescale 1ns / 1ps

module g2e_cordic
	import g2e_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [ANG_W-1:0] angle,
	output logic                    out_valid,
	output logic signed [31:0]      sin_val,
	output logic signed [31:0]      cos_val
);

	logic signed [33:0] a_w;
	logic signed [33:0] wrap_c;
	logic signed [33:0] fold_c;
	logic               flip_c;

	logic signed [33:0] wr_s1;
	logic               v_s1;

	logic signed [32:0] x_s [CORDIC_STAGES+1];
	logic signed [32:0] y_s [CORDIC_STAGES+1];
	logic signed [32:0] z_s [CORDIC_STAGES+1];
	logic               flip_s [CORDIC_STAGES+1];
	logic               v_s [CORDIC_STAGES+1];

	logic signed [32:0] xf;

	assign a_w = 34'(angle);

	always_comb begin
		if (a_w > PI_Q30) begin
			wrap_c = a_w - TWO_PI_Q30;
		end else if (a_w < -PI_Q30) begin
			wrap_c = a_w + TWO_PI_Q30;
		end else begin
			wrap_c = a_w;
		end
	end

	always_comb begin
		flip_c = 1'b1;
		if (wr_s1 > HALF_PI_Q30) begin
			fold_c = PI_Q30 - wr_s1;
		end else if (wr_s1 < -HALF_PI_Q30) begin
			fold_c = -PI_Q30 - wr_s1;
		end else begin
			fold_c = wr_s1;
			flip_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wr_s1     <= wrap_c;
		x_s[0]    <= GAIN_Q30;
		y_s[0]    <= '0;
		z_s[0]    <= 33'(fold_c);
		flip_s[0] <= flip_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s[0] <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s[0] <= v_s1;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [32:0] xs;
		logic signed [32:0] ys;
		logic signed [32:0] at;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = 33'(atan_entry(i));

		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - at;
			end else begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + at;
			end
			flip_s[i+1] <= flip_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	assign xf = flip_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (y_s[CORDIC_STAGES] > ONE_Q30) begin
			sin_val <= 32'(ONE_Q30);
		end else if (y_s[CORDIC_STAGES] < -ONE_Q30) begin
			sin_val <= 32'(-ONE_Q30);
		end else begin
			sin_val <= 32'(y_s[CORDIC_STAGES]);
		end
		if (xf > ONE_Q30) begin
			cos_val <= 32'(ONE_Q30);
		end else if (xf < -ONE_Q30) begin
			cos_val <= 32'(-ONE_Q30);
		end else begin
			cos_val <= 32'(xf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[CORDIC_STAGES];
		end
	end

endmodule

FILE: hw/rtl/g2e_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on g2e_pkg.
`timescale 1ns / 1ps

module g2e_isqrt
	import g2e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [62:0] radicand,
	output logic        out_valid,
	output logic [31:0] root
);

	logic [63:0] rem_s [ISQRT_LAT];
	logic [31:0] rt_s [ISQRT_LAT];
	logic        v_s [ISQRT_LAT];

	for (genvar j = 0; j < ISQRT_LAT; j++) begin : g_bit
		localparam int K = ISQRT_LAT - 1 - j;
		logic [63:0] rem_in;
		logic [31:0] rt_in;
		logic        v_in;
		logic [63:0] trial;

		if (j == 0) begin : g_first
			assign rem_in = 64'(radicand);
			assign rt_in  = '0;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign rt_in  = rt_s[j-1];
			assign v_in   = v_s[j-1];
		end

		// (R + 2^K)^2 - R^2
		assign trial = (64'(rt_in) << (K + 1)) + (64'd1 << (2 * K));

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_s[j] <= rem_in - trial;
				rt_s[j]  <= rt_in | (32'd1 << K);
			end else begin
				rem_s[j] <= rem_in;
				rt_s[j]  <= rt_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_in;
			end
		end
	end

	assign root      = rt_s[ISQRT_LAT-1];
	assign out_valid = v_s[ISQRT_LAT-1];

endmodule

FILE: hw/rtl/g2e_div.sv
// Pipelined restoring divider for the prime-vertical radius N = a*2^41 / root,
// rounded, saturated at 2^35. Depends on g2e_pkg.
`timescale 1ns / 1ps

module g2e_div
	import g2e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [22:0] axis,
	input  logic [31:0] root,
	output logic        out_valid,
	output logic [35:0] radius
);

	logic [63:0] num_p1;
	logic [31:0] root_p1;
	logic        v_p1;

	logic [63:0] num_p2;
	logic [31:0] root_p2;
	logic        ovf_p2;
	logic        v_p2;

	logic [63:0]          rem_s [QUOT_BITS];
	logic [QUOT_BITS-1:0] q_s [QUOT_BITS];
	logic [31:0]          rt_s [QUOT_BITS];
	logic                 ovf_s [QUOT_BITS];
	logic                 v_s [QUOT_BITS];

	always_ff @(posedge clk) begin
		num_p1  <= {axis, 41'd0} + 64'(root >> 1);
		root_p1 <= root;
		num_p2  <= num_p1;
		root_p2 <= root_p1;
		ovf_p2  <= {4'd0, num_p1} >= {root_p1, 36'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else begin
			v_p1 <= in_valid;
			v_p2 <= v_p1;
		end
	end

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_bit
		localparam int K = QUOT_BITS - 1 - j;
		logic [63:0]          rem_in;
		logic [QUOT_BITS-1:0] q_in;
		logic [31:0]          rt_in;
		logic                 ovf_in;
		logic                 v_in;
		logic [67:0]          trial;

		if (j == 0) begin : g_first
			assign rem_in = num_p2;
			assign q_in   = '0;
			assign rt_in  = root_p2;
			assign ovf_in = ovf_p2;
			assign v_in   = v_p2;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign rt_in  = rt_s[j-1];
			assign ovf_in = ovf_s[j-1];
			assign v_in   = v_s[j-1];
		end

		assign trial = 68'(rt_in) << K;

		always_ff @(posedge clk) begin
			if ({4'd0, rem_in} >= trial) begin
				rem_s[j] <= rem_in - trial[63:0];
				q_s[j]   <= q_in | (QUOT_BITS'(1) << K);
			end else begin
				rem_s[j] <= rem_in;
				q_s[j]   <= q_in;
			end
			rt_s[j]  <= rt_in;
			ovf_s[j] <= ovf_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ovf_s[QUOT_BITS-1] || (q_s[QUOT_BITS-1] > N_MAX)) begin
			radius <= N_MAX;
		end else begin
			radius <= q_s[QUOT_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[QUOT_BITS-1];
		end
	end

endmodule

FILE: hw/rtl/g2e_smul.sv
// Signed length times signed Q30 factor, rounded half away from zero on the
// magnitude; four register stages. Depends on g2e_pkg.
`timescale 1ns / 1ps

module g2e_smul
	import g2e_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [37:0] len,
	input  logic signed [31:0] factor,
	output logic               out_valid,
	output logic signed [37:0] product
);

	logic [37:0] mv_m1;
	logic [30:0] mc_m1;
	logic        neg_m1;
	logic        v_m1;

	logic [49:0] plo_m2;
	logic [49:0] phi_m2;
	logic        neg_m2;
	logic        v_m2;

	logic [68:0] sum_c;
	logic [37:0] mag_m3;
	logic        neg_m3;
	logic        v_m3;

	always_ff @(posedge clk) begin
		mv_m1  <= len[37] ? 38'(38'd0 - len) : 38'(len);
		mc_m1  <= factor[31] ? 31'(32'd0 - factor) : 31'(factor);
		neg_m1 <= len[37] ^ factor[31];
		plo_m2 <= mv_m1[18:0] * mc_m1;
		phi_m2 <= mv_m1[37:19] * mc_m1;
		neg_m2 <= neg_m1;
		mag_m3 <= sum_c[67:30];
		neg_m3 <= neg_m2;
		product <= neg_m3 ? 38'(38'd0 - mag_m3) : mag_m3;
	end

	assign sum_c = (69'(phi_m2) << 19) + 69'(plo_m2) + (69'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1      <= 1'b0;
			v_m2      <= 1'b0;
			v_m3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_m1      <= in_valid;
			v_m2      <= v_m1;
			v_m3      <= v_m2;
			out_valid <= v_m3;
		end
	end

endmodule

FILE: hw/rtl/g2e_checker.sv
// Port-level checks for geodetic_to_ecef_top, bound to the top level.
// Depends on g2e_pkg.
`timescale 1ns / 1ps

module g2e_checker
	import g2e_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [30:0] latitude,
	input logic signed [31:0] longitude,
	input logic signed [30:0] height,
	input logic signed [34:0] ecef_x,
	input logic signed [34:0] ecef_y,
	input logic signed [34:0] ecef_z,
	input logic               wr_en,
	input logic [0:0]         wr_index,
	input logic [31:0]        wr_data
);

	// every result beat comes from a beat taken a fixed time earlier
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result beat without matching input beat");

	// every input beat yields a result beat
	a_source_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##TOTAL_LAT done)
		else $error("input beat lost");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("pipeline refused a beat");

	a_quiet_after_reset: assert property (@(posedge clk) $past(!arst_n) |-> !done)
		else $error("result beat right after reset");

endmodule

bind geodetic_to_ecef_top g2e_checker u_g2e_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for geodetic_to_ecef_top: a bit-exact fixed-point
// predictor of the conversion checks every result beat, in order.
// Depends on g2e_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
	import g2e_pkg::*;

	localparam int  LIMIT_CYCLES = 600000;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  RAND_ITEMS   = 300;	// per random phase, four phases
	localparam longint LAT_MAX   = 843314857;
	localparam longint LON_MAX   = 1686629713;

	typedef struct {
		logic signed [34:0] x;
		logic signed [34:0] y;
		logic signed [34:0] z;
	} ecef_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               done;
	logic signed [30:0] latitude = '0;
	logic signed [31:0] longitude = '0;
	logic signed [30:0] height = '0;
	logic signed [34:0] ecef_x;
	logic signed [34:0] ecef_y;
	logic signed [34:0] ecef_z;
	logic               wr_en = 1'b0;
	logic [0:0]         wr_index = REG_AXIS;
	logic [31:0]        wr_data = '0;

	// predictor's copy of the configuration
	logic [22:0] axis_m = AXIS_RESET;
	logic [31:0] ecc_m  = ECC_RESET;

	ecef_t expected_ecef_q[$];
	int    mismatch_count = 0;
	int    result_count   = 0;
	int    item_count     = 0;
	int    cycle_count    = 0;
	int    idle_pct       = 0;

	geodetic_to_ecef_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.latitude(latitude), .longitude(longitude), .height(height),
		.ecef_x(ecef_x), .ecef_y(ecef_y), .ecef_z(ecef_z),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// floor(atan(2^-i) * 2^30); past the table it is 2^(30-i) - 1
	function automatic longint arctan_q30(input int i);
		longint head[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
			64'h001FFFFD};
		if (i < 10)
			return head[i];
		if (i <= 30)
			return (64'sd1 <<< (30 - i)) - 1;
		return 0;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rotation CORDIC on a Q30 angle, with reduction and fold to +-pi/2
	function automatic void sin_cos_q30(input longint ang, output longint s,
		output longint c);
		longint pi_v, half_v, two_v, r, x, y, z, xs, ys;
		bit     flip;
		pi_v = longint'(PI_Q30);
		half_v = longint'(HALF_PI_Q30);
		two_v = longint'(TWO_PI_Q30);
		flip = 1'b0;
		r = ang % two_v;	// truncates toward zero
		if (r > pi_v) r -= two_v;
		if (r < -pi_v) r += two_v;
		if (r > half_v) begin
			r = pi_v - r;
			flip = 1'b1;
		end else if (r < -half_v) begin
			r = -pi_v - r;
			flip = 1'b1;
		end
		x = longint'(GAIN_Q30);
		y = 0;
		z = r;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arctan_q30(i);
			end else begin
				x += ys; y -= xs; z += arctan_q30(i);
			end
		end
		if (flip) x = -x;
		s = clip(y, -longint'(ONE_Q30), longint'(ONE_Q30));
		c = clip(x, -longint'(ONE_Q30), longint'(ONE_Q30));
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] rem, res, b;
		rem = v;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// round(m * c / 2^s), ties up, on magnitudes
	function automatic logic [127:0] round_mul(input logic [127:0] m, input logic [127:0] c,
		input int s);
		return (m * c + (128'd1 << (s - 1))) >> s;
	endfunction

	function automatic longint signed_mul_q30(input longint v, input longint c);
		bit     neg;
		longint p;
		neg = (v < 0) != (c < 0);
		p = longint'(round_mul(v < 0 ? -v : v, c < 0 ? -c : c, 30));
		return neg ? -p : p;
	endfunction

	function automatic ecef_t geodetic_to_ecef_predict(input logic signed [30:0] lat_in,
		input logic signed [31:0] lon_in, input logic signed [30:0] h_in);
		longint      sl, cl, so, co, h, nh, nz, x, y, z;
		logic [127:0] s2, e2s2, d, root, n;
		ecef_t       e;
		h = longint'(h_in);
		sin_cos_q30(longint'(lat_in) <<< ANG_SHIFT, sl, cl);
		sin_cos_q30(longint'(lon_in) <<< ANG_SHIFT, so, co);
		s2 = (128'(sl * sl) + (128'd1 << 27)) >> 28;
		e2s2 = (128'(ecc_m) * s2 + (128'd1 << 31)) >> 32;
		d = (128'd1 << 32) - e2s2;
		root = 128'(int_sqrt(64'(d << 30)));
		n = ((128'(axis_m) << 41) + (root >> 1)) / root;
		if (n > 128'(N_MAX)) n = 128'(N_MAX);
		nh = longint'(n) + h;
		nz = longint'(round_mul(n, (128'd1 << 32) - 128'(ecc_m), 32)) + h;
		x = signed_mul_q30(signed_mul_q30(nh, cl), co);
		y = signed_mul_q30(signed_mul_q30(nh, cl), so);
		z = signed_mul_q30(nz, sl);
		e.x = 35'(clip(x, longint'(OUT_MIN), longint'(OUT_MAX)));
		e.y = 35'(clip(y, longint'(OUT_MIN), longint'(OUT_MAX)));
		e.z = 35'(clip(z, longint'(OUT_MIN), longint'(OUT_MAX)));
		return e;
	endfunction

	// ---------------------------------------------------------------
	// Result checker: done marks a one-cycle result beat, no back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			result_count++;
			if (expected_ecef_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result beat x=%0d y=%0d z=%0d",
					$time, ecef_x, ecef_y, ecef_z);
			end else begin
				ecef_t e;
				e = expected_ecef_q.pop_front();
				if (ecef_x !== e.x) begin
					mismatch_count++;
					$display("%0t: ecef_x expected %0d actual %0d", $time, e.x, ecef_x);
				end
				if (ecef_y !== e.y) begin
					mismatch_count++;
					$display("%0t: ecef_y expected %0d actual %0d", $time, e.y, ecef_y);
				end
				if (ecef_z !== e.z) begin
					mismatch_count++;
					$display("%0t: ecef_z expected %0d actual %0d", $time, e.z, ecef_z);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_ecef_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus tasks; all are called at a rising edge
	// ---------------------------------------------------------------

	// one input beat; start stays high so back-to-back beats need no toggle
	task automatic send_position(input logic signed [30:0] lat,
		input logic signed [31:0] lon, input logic signed [30:0] h);
		start <= 1'b1;
		latitude <= lat;
		longitude <= lon;
		height <= h;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_ecef_q.push_back(geodetic_to_ecef_predict(lat, lon, h));
		item_count++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// hold off until every expected beat is back, then let the pipe settle
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (expected_ecef_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one write cycle, then wr_en low again, so two writes never run back to back
	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_AXIS)
			axis_m = val[22:0];
		else
			ecc_m = val;
		@(posedge clk);
	endtask

	task automatic set_ellipsoid(input logic [31:0] axis, input logic [31:0] ecc);
		drain_pipe();
		write_reg(REG_AXIS, axis);
		write_reg(REG_ECC, ecc);
	endtask

	// random position: mostly in the nominal range, sometimes full width
	task automatic send_random_position();
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [30:0] h;
		if ($urandom_range(9) < 8) begin
			lat = 31'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
			lon = 32'(longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX);
			h = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($signed($urandom_range(20000000)) - 1000000);
		end else begin
			lat = 31'($urandom);
			lon = 32'($urandom);
			h = 31'($urandom);
		end
		send_position(lat, lon, h);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset ellipsoid: field extremes, poles, equator, angle wrap past +-pi
	task automatic test_default_ellipsoid();
		idle_pct = 0;
		send_position(0, 0, 0);
		send_position(31'(LAT_MAX), 0, 0);
		send_position(-31'(LAT_MAX), 32'(LON_MAX), 0);
		send_position(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h3FFF_FFFF);
		send_position(31'h4000_0000, 32'h8000_0000, 31'h4000_0000);
		send_position(0, 32'(LON_MAX / 2), 31'h3FFF_FFFF);
		send_position(0, -32'(LON_MAX / 2), 31'h4000_0000);
		send_position(31'(LAT_MAX / 2 + 1), 32'(LON_MAX + 1), 1024);	// past pi
		send_position(31'(LAT_MAX + 1000), -32'(LON_MAX + 1), -1024);	// past a pole
		send_position(-1, -1, -1);
	endtask

	// register extremes: zero axis, largest axis, zero and full eccentricity
	task automatic test_ellipsoid_extremes();
		set_ellipsoid(0, ECC_RESET);	// zero axis gives N = 0
		send_position(31'(LAT_MAX / 3), 32'(LON_MAX / 5), 31'h3FFF_FFFF);
		send_position(-31'(LAT_MAX / 3), 32'(LON_MAX), 31'h4000_0000);
		set_ellipsoid(32'hFFFF_FFFF, 0);	// wider than the register, sphere
		send_position(31'(LAT_MAX / 4), -32'(LON_MAX / 3), 31'h3FFF_FFFF);
		send_position(31'(LAT_MAX), 0, 0);
		set_ellipsoid(7000000, 32'hFFFF_FFFF);	// radius saturates near the poles
		send_position(31'(LAT_MAX), 0, 0);
		send_position(31'(LAT_MAX - 5), 32'(LON_MAX / 2), 31'h3FFF_FFFF);
		send_position(-31'(LAT_MAX), -32'(LON_MAX), 31'h4000_0000);
		set_ellipsoid(6000000, 32'h8000_0000);
		send_position(31'(LAT_MAX / 2), 32'(LON_MAX / 2), 0);
	endtask

	task automatic run_random_phase(input int pct);
		idle_pct = pct;
		repeat (RAND_ITEMS) send_random_position();
		idle_pct = 0;
	endtask

	// four random phases, each with its own ellipsoid; idle gaps in the second and third
	task automatic test_random_traffic();
		set_ellipsoid(AXIS_RESET, ECC_RESET);
		run_random_phase(0);
		set_ellipsoid($urandom_range(6000000, 7000000), $urandom);
		run_random_phase(85);
		set_ellipsoid($urandom, $urandom_range(0, 32'h1000_0000));
		run_random_phase(16);
		set_ellipsoid(6000000, $urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
		run_random_phase(0);
		drain_pipe();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_ellipsoid();
		test_ellipsoid_extremes();
		test_random_traffic();
		$display("covered %0d positions and %0d result beats over several ellipsoids,",
			item_count, result_count);
		$display("including zero axis, saturated radius and idle gaps on the input side");
		if (mismatch_count == 0 && expected_ecef_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
